FILE: rtl/i2cm_pkg.sv
// Shared types and constants for the I2C master transfer unit.
package i2cm_pkg;

   localparam int CMD_W  = 2;
   localparam int BYTE_W = 8;
   localparam int REQ_W  = 40;
   localparam int RSP_W  = 16;

   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   localparam logic [BYTE_W-1:0] RD_BIT = 8'h01;
   localparam logic [2:0]        LAST_BIT = 3'd7;

   typedef enum logic [1:0] {
      STG_DEV  = 2'd0,
      STG_SUB  = 2'd1,
      STG_RDEV = 2'd2,
      STG_DATA = 2'd3
   } stage_type;

   typedef enum logic [16:0] {
      PH_IDLE     = 17'b00000000000000001,
      PH_RS_REL   = 17'b00000000000000010,
      PH_ST_HIGH  = 17'b00000000000000100,
      PH_ST_LOW   = 17'b00000000000001000,
      PH_TX_LOW   = 17'b00000000000010000,
      PH_TX_HIGH  = 17'b00000000000100000,
      PH_TX_REL   = 17'b00000000001000000,
      PH_ACK_HIGH = 17'b00000000010000000,
      PH_ACK_LOW  = 17'b00000000100000000,
      PH_RX_LOW   = 17'b00000001000000000,
      PH_RX_HIGH  = 17'b00000010000000000,
      PH_MA_LOW   = 17'b00000100000000000,
      PH_MA_HIGH  = 17'b00001000000000000,
      PH_MA_REL   = 17'b00010000000000000,
      PH_SP_LOW   = 17'b00100000000000000,
      PH_SP_HIGH  = 17'b01000000000000000,
      PH_SP_REL   = 17'b10000000000000000
   } phase_type;

endpackage

FILE: rtl/i2c_master_eeprom_transfer_unit.sv
// I2C master bus sequencer, one bus tick per request transfer.
// The result of a tick is registered and presented in the cycle after its request transfer.
// Throughput: one tick per cycle while rsp_tready holds; the result register frees as it is taken.
// Reset (synchronous, active high): bus idle, ack wait zero, result register empty.
module i2c_master_eeprom_transfer_unit
   import i2cm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // command[1:0], device_address[9:2], sub_address[17:10], write_data[25:18],
   // byte_count[33:26], sda_in[34], zero fill
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // scl_out[0], sda_out[1], busy_res[2], read_valid[3], read_data[11:4],
   // ack_missing[12], zero fill
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tlast,
   input  logic             csr_wen,
   input  logic [BYTE_W-1:0] csr_wdata
);

   phase_type         phase_ff, phase_in;
   stage_type         stage_ff, stage_in;
   logic [2:0]        bit_index_ff, bit_index_in;
   logic [BYTE_W-1:0] shift_ff, shift_in;
   logic [BYTE_W-1:0] bytes_left_ff, bytes_left_in;
   logic [BYTE_W-1:0] dev_addr_ff, dev_addr_in;
   logic [BYTE_W-1:0] sub_addr_ff, sub_addr_in;
   logic [BYTE_W-1:0] data_ff, data_in;
   logic              is_read_ff, is_read_in;
   logic [BYTE_W-1:0] wait_count_ff, wait_count_in;
   logic              nack_seen_ff, nack_seen_in;
   logic [BYTE_W-1:0] ack_wait_ff;

   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [CMD_W-1:0]  cmd;
   logic              sda_i;
   logic              scl_o, sda_o, busy_o, rv_o, rl_o;
   logic [BYTE_W-1:0] rd_o;
   logic [BYTE_W-1:0] shifted_rx;
   logic [BYTE_W-1:0] bytes_dec;
   logic              accept;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign cmd        = req_tdata[1:0];
   assign sda_i      = req_tdata[34];
   assign shifted_rx = {shift_ff[BYTE_W-2:0], sda_i};
   assign bytes_dec  = (bytes_left_ff != '0) ? bytes_left_ff - 8'd1 : bytes_left_ff;

   always_comb begin
      phase_in      = phase_ff;
      stage_in      = stage_ff;
      bit_index_in  = bit_index_ff;
      shift_in      = shift_ff;
      bytes_left_in = bytes_left_ff;
      dev_addr_in   = dev_addr_ff;
      sub_addr_in   = sub_addr_ff;
      data_in       = data_ff;
      is_read_in    = is_read_ff;
      wait_count_in = wait_count_ff;
      nack_seen_in  = nack_seen_ff;
      scl_o  = 1'b1;
      sda_o  = 1'b1;
      busy_o = 1'b1;
      rv_o   = 1'b0;
      rd_o   = '0;
      rl_o   = 1'b0;

      case (phase_ff)
         PH_IDLE: begin
            if (cmd == CMD_WRITE || cmd == CMD_READ) begin
               dev_addr_in   = req_tdata[9:2];
               sub_addr_in   = req_tdata[17:10];
               data_in       = req_tdata[25:18];
               bytes_left_in = req_tdata[33:26];
               is_read_in    = (cmd == CMD_READ);
               nack_seen_in  = 1'b0;
               wait_count_in = '0;
               bit_index_in  = '0;
               shift_in      = '0;
               stage_in      = STG_DEV;
               phase_in      = PH_ST_HIGH;
            end else begin
               busy_o = 1'b0;
            end
         end
         PH_RS_REL: begin
            scl_o    = 1'b0;
            phase_in = PH_ST_HIGH;
         end
         PH_ST_HIGH: phase_in = PH_ST_LOW;
         PH_ST_LOW: begin
            sda_o        = 1'b0;
            shift_in     = (stage_ff == STG_RDEV) ? (dev_addr_ff | RD_BIT) : dev_addr_ff;
            bit_index_in = '0;
            phase_in     = PH_TX_LOW;
         end
         PH_TX_LOW: begin
            scl_o    = 1'b0;
            sda_o    = shift_ff[BYTE_W-1];
            phase_in = PH_TX_HIGH;
         end
         PH_TX_HIGH: begin
            sda_o    = shift_ff[BYTE_W-1];
            shift_in = {shift_ff[BYTE_W-2:0], 1'b0};
            if (bit_index_ff == LAST_BIT) begin
               bit_index_in = '0;
               phase_in     = PH_TX_REL;
            end else begin
               bit_index_in = bit_index_ff + 3'd1;
               phase_in     = PH_TX_LOW;
            end
         end
         PH_TX_REL: begin
            scl_o         = 1'b0;
            wait_count_in = '0;
            phase_in      = PH_ACK_HIGH;
         end
         PH_ACK_HIGH: begin
            if (!sda_i || wait_count_ff >= ack_wait_ff) begin
               if (sda_i) nack_seen_in = 1'b1;
               phase_in = PH_ACK_LOW;
            end else begin
               wait_count_in = wait_count_ff + 8'd1;
            end
         end
         PH_ACK_LOW: begin
            scl_o = 1'b0;
            case (stage_ff)
               STG_DEV: begin
                  stage_in     = STG_SUB;
                  shift_in     = sub_addr_ff;
                  bit_index_in = '0;
                  phase_in     = PH_TX_LOW;
               end
               STG_SUB: begin
                  if (is_read_ff) begin
                     stage_in = STG_RDEV;
                     phase_in = PH_RS_REL;
                  end else if (bytes_left_ff != '0) begin
                     stage_in     = STG_DATA;
                     shift_in     = data_ff;
                     bit_index_in = '0;
                     phase_in     = PH_TX_LOW;
                  end else begin
                     phase_in = PH_SP_LOW;
                  end
               end
               STG_RDEV: begin
                  if (bytes_left_ff != '0) begin
                     shift_in     = '0;
                     bit_index_in = '0;
                     phase_in     = PH_RX_LOW;
                  end else begin
                     phase_in = PH_SP_LOW;
                  end
               end
               default: begin
                  bytes_left_in = bytes_dec;
                  if (bytes_dec != '0) begin
                     shift_in     = data_ff;
                     bit_index_in = '0;
                     phase_in     = PH_TX_LOW;
                  end else begin
                     phase_in = PH_SP_LOW;
                  end
               end
            endcase
         end
         PH_RX_LOW: begin
            scl_o    = 1'b0;
            phase_in = PH_RX_HIGH;
         end
         PH_RX_HIGH: begin
            shift_in = shifted_rx;
            if (bit_index_ff == LAST_BIT) begin
               bit_index_in  = '0;
               rv_o          = 1'b1;
               rd_o          = shifted_rx;
               rl_o          = (bytes_left_ff <= 8'd1);
               bytes_left_in = bytes_dec;
               phase_in      = PH_MA_LOW;
            end else begin
               bit_index_in = bit_index_ff + 3'd1;
               phase_in     = PH_RX_LOW;
            end
         end
         PH_MA_LOW: begin
            scl_o    = 1'b0;
            sda_o    = (bytes_left_ff == '0);
            phase_in = PH_MA_HIGH;
         end
         PH_MA_HIGH: begin
            sda_o    = (bytes_left_ff == '0);
            phase_in = PH_MA_REL;
         end
         PH_MA_REL: begin
            scl_o = 1'b0;
            if (bytes_left_ff != '0) begin
               shift_in     = '0;
               bit_index_in = '0;
               phase_in     = PH_RX_LOW;
            end else begin
               phase_in = PH_SP_LOW;
            end
         end
         PH_SP_LOW: begin
            scl_o    = 1'b0;
            sda_o    = 1'b0;
            phase_in = PH_SP_HIGH;
         end
         PH_SP_HIGH: begin
            sda_o    = 1'b0;
            phase_in = PH_SP_REL;
         end
         default: phase_in = PH_IDLE;
      endcase

      rsp_data_in = {3'b000, nack_seen_in, rd_o, rv_o, busy_o, sda_o, scl_o};
      rsp_last_in = rl_o;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         stage_ff      <= STG_DEV;
         bit_index_ff  <= '0;
         shift_ff      <= '0;
         bytes_left_ff <= '0;
         dev_addr_ff   <= '0;
         sub_addr_ff   <= '0;
         data_ff       <= '0;
         is_read_ff    <= 1'b0;
         wait_count_ff <= '0;
         nack_seen_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff      <= phase_in;
            stage_ff      <= stage_in;
            bit_index_ff  <= bit_index_in;
            shift_ff      <= shift_in;
            bytes_left_ff <= bytes_left_in;
            dev_addr_ff   <= dev_addr_in;
            sub_addr_ff   <= sub_addr_in;
            data_ff       <= data_in;
            is_read_ff    <= is_read_in;
            wait_count_ff <= wait_count_in;
            nack_seen_ff  <= nack_seen_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_wait_ff <= '0;
      end else if (csr_wen) begin
         ack_wait_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

endmodule
